// ===== hw/rtl/lcdst_pkg.sv =====
// shared types, constants and codes of the lcd scanline mode timing core
package lcdst_pkg;

    // line and mode timing
    localparam logic [8:0] DOTS_PER_LINE = 9'd456;
    localparam logic [8:0] OAM_END_DOT   = 9'd80;
    localparam logic [7:0] VBLANK_LINE   = 8'd144;
    localparam logic [7:0] WRAP_LINE     = 8'd153;

    // mode codes in status bits 1:0
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // status bit positions
    localparam int COINC_POS      = 2;
    localparam int SRC_HBLANK_POS = 3;
    localparam int SRC_VBLANK_POS = 4;
    localparam int SRC_OAM_POS    = 5;
    localparam int SRC_COINC_POS  = 6;

    // configuration register indexes (taken from paddr bit 2)
    localparam logic REG_LINE_COMPARE = 1'b0;
    localparam logic REG_XFER_END     = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0] LINE_COMPARE_RST = 8'd0;
    localparam logic [8:0] XFER_END_RST     = 9'd253;

    // dot timing state
    typedef struct packed {
        logic [6:0] status;
        logic [7:0] line;
        logic [8:0] dot;
    } lcd_state_t;

    // configuration seen by the dot unit
    typedef struct packed {
        logic [7:0] line_compare;
        logic [8:0] transfer_end_dot;
    } lcd_cfg_t;

    // pulses raised on one dot or collected over an item
    typedef struct packed {
        logic stat;
        logic vblank;
        logic frame;
    } lcd_irq_t;

endpackage

// ===== hw/rtl/lcd_scanline_mode_timing_core.sv =====
// top level of the lcd scanline mode timing core: sequencer, state and output register
//
//  channel  | ports        | content
//  ---------+--------------+---------------------------------------------------
//  input    | s_tvalid ... | dots per transfer
//  result   | m_tvalid ... | mode, line, status, stat, vblank and frame pulses
//  config   | apb p*       | line compare (0x0), transfer end dot (0x4)
//
//  an item is accepted at the input, stepped one dot at a time through the single
//  dot step unit, then loaded into the output register
//  the output register frees the input side; a result waits in the sequencer only
//  while the previous result is still held by a stalled m_tready
//  reset (aresetn low, synchronous) clears the timing state to line 0, dot 0, h-blank
module lcd_scanline_mode_timing_core
    import lcdst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [4:0] dots, [7:5] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [1:0] mode, [9:2] line, [16:10] status,
                                    // [17] stat_irq, [18] vblank_irq,
                                    // [19] frame_done, [23:20] zero
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    lcd_state_t  cur_reg, cur_next;
    lcd_irq_t    irq_reg, irq_next;
    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;

    lcd_cfg_t    cfg;
    lcd_state_t  step_state;
    lcd_irq_t    step_irq;
    logic        in_xfer;
    logic        out_free;

    // configuration registers
    lcdst_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared dot step unit
    lcdst_dot_unit u_dot (
        .cur (cur_reg),
        .cfg (cfg),
        .nxt (step_state),
        .irq (step_irq)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        irq_next     = irq_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // release of the held result
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cnt_next   = s_tdata[4:0];
                    irq_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg != 5'd0) begin
                    // one dot per cycle
                    cur_next        = step_state;
                    irq_next.stat   = irq_reg.stat   | step_irq.stat;
                    irq_next.vblank = irq_reg.vblank | step_irq.vblank;
                    irq_next.frame  = irq_reg.frame  | step_irq.frame;
                    cnt_next        = cnt_reg - 5'd1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, irq_reg.frame, irq_reg.vblank, irq_reg.stat,
                                    cur_reg.status, cur_reg.line, cur_reg.status[1:0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and timing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 5'd0;
            cur_reg     <= '0;
            irq_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_reg     <= cur_next;
            irq_reg     <= irq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // an accepted transfer always occupies the sequencer on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("sequencer ready right after accepting a transfer");

    // no dots left over once the sequencer is idle
    a_idle_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg == 5'd0))
        else $error("dot count pending while idle");

    // the wrap line is never held
    a_no_wrap_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg.line != WRAP_LINE)
        else $error("line counter holds the wrap line");

    // a frame wrap in a result leaves the line at zero
    a_frame_line_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[19]) |-> (m_data_reg[9:2] == 8'd0))
        else $error("frame done reported away from line zero");

    // a v-blank pulse in a result leaves the mode at v-blank
    a_vblank_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[18]) |-> (m_data_reg[1:0] == MODE_VBLANK))
        else $error("v-blank pulse reported outside v-blank");

endmodule

// ===== hw/rtl/lcdst_cfg.sv =====
// apb register file holding line compare and transfer end dot
module lcdst_cfg
    import lcdst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output lcd_cfg_t    cfg
);

    logic [7:0] lyc_reg;
    logic [8:0] xend_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lyc_reg  <= LINE_COMPARE_RST;
            xend_reg <= XFER_END_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LINE_COMPARE: lyc_reg  <= pwdata[7:0];
                REG_XFER_END:     xend_reg <= pwdata[8:0];
                default:          lyc_reg  <= lyc_reg;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_LINE_COMPARE: prdata = {24'd0, lyc_reg};
            REG_XFER_END:     prdata = {23'd0, xend_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.line_compare     = lyc_reg;
    assign cfg.transfer_end_dot = xend_reg;

endmodule

// ===== hw/rtl/lcdst_dot_unit.sv =====
// shared dot step unit: advances the timing state by a single dot
module lcdst_dot_unit
    import lcdst_pkg::*;
(
    input  lcd_state_t cur,
    input  lcd_cfg_t   cfg,
    output lcd_state_t nxt,
    output lcd_irq_t   irq
);

    logic [6:0] s;
    logic [7:0] l;
    logic [8:0] d;
    logic       p_stat;
    logic       p_vbl;
    logic       p_frame;

    always_comb begin
        s       = cur.status;
        l       = cur.line;
        d       = cur.dot;
        p_stat  = 1'b0;
        p_vbl   = 1'b0;
        p_frame = 1'b0;

        // mode transitions at the boundary dots
        unique case (s[1:0])
            MODE_OAM: begin
                if (d == OAM_END_DOT) begin
                    s[1:0] = MODE_XFER;
                end
            end
            MODE_XFER: begin
                if (d == cfg.transfer_end_dot) begin
                    s = 7'd0;
                    s[COINC_POS]      = cur.status[COINC_POS];
                    s[SRC_HBLANK_POS] = 1'b1;
                    s[1:0]            = MODE_HBLANK;
                    p_stat            = 1'b1;
                end
            end
            MODE_HBLANK: begin
                if (d == DOTS_PER_LINE) begin
                    d = 9'd0;
                    l = l + 8'd1;
                    s = 7'd0;
                    s[COINC_POS] = cur.status[COINC_POS];
                    if (l == VBLANK_LINE) begin
                        s[1:0]            = MODE_VBLANK;
                        s[SRC_VBLANK_POS] = 1'b1;
                        p_vbl             = 1'b1;
                    end else begin
                        s[1:0]         = MODE_OAM;
                        s[SRC_OAM_POS] = 1'b1;
                    end
                    p_stat = 1'b1;
                end
            end
            MODE_VBLANK: begin
                if (d == DOTS_PER_LINE) begin
                    d = 9'd0;
                    l = l + 8'd1;
                    if (l == WRAP_LINE) begin
                        l = 8'd0;
                        s = 7'd0;
                        s[COINC_POS]   = cur.status[COINC_POS];
                        s[1:0]         = MODE_OAM;
                        s[SRC_OAM_POS] = 1'b1;
                        p_stat         = 1'b1;
                        p_frame        = 1'b1;
                    end
                end
            end
            default: begin
                s = cur.status;
            end
        endcase

        // dot count wraps at the 9-bit boundary
        d = d + 9'd1;

        // line compare coincidence
        if (l == cfg.line_compare) begin
            s[SRC_HBLANK_POS] = 1'b0;
            s[SRC_VBLANK_POS] = 1'b0;
            s[SRC_OAM_POS]    = 1'b0;
            s[COINC_POS]      = 1'b1;
            s[SRC_COINC_POS]  = 1'b1;
            p_stat            = 1'b1;
        end else begin
            s[COINC_POS] = 1'b0;
        end

        nxt.status = s;
        nxt.line   = l;
        nxt.dot    = d;
        irq.stat   = p_stat;
        irq.vblank = p_vbl;
        irq.frame  = p_frame;
    end

endmodule
